@@ src/lbps_pkg.sv @@
// Shared constants, types and the pattern table for the warning LED sequencer.
// Used by every module of the block; depends on nothing.
package lbps_pkg;

  localparam int NUM_SEQUENCES = 4;
  localparam int SEQ_LENGTH = 64;
  localparam int TICK_MS = 10;

  localparam int POS_W = $clog2(SEQ_LENGTH);
  localparam int SEL_W = 2;

  localparam logic [7:0] MODE_ONCE = 8'hfe;
  localparam logic [7:0] MARK_END = 8'hff;

  localparam logic [14:0] INTERVAL_RESET = 15'd400;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_BLINK_START = 2'd1;
  localparam logic [1:0] FUNC_BLINK_STOP = 2'd2;
  localparam logic [1:0] FUNC_SPECIAL = 2'd3;

  typedef struct packed {
    logic tick;
    logic blink_start;
    logic blink_stop;
    logic special_start;
    logic special_stop;
  } ctrl_t;

  function automatic logic [7:0] rom_read(input logic [SEL_W-1:0] sel,
                                          input logic [POS_W-1:0] pos);
    logic [7:0] v;
    v = 8'd0;
    unique case (sel)
      2'd0: begin
        if (pos == 6'd0) begin
          v = MODE_ONCE;
        end else if (pos == 6'd37) begin
          v = MARK_END;
        end else if (pos < 6'd37) begin
          if (pos[0]) begin
            v = pos[1] ? 8'd0 : 8'd1;
          end else if (pos >= 6'd14 && pos <= 6'd24) begin
            v = 8'd40;
          end else begin
            v = 8'd15;
          end
        end
      end
      2'd1: begin
        unique case (pos)
          6'd1: v = 8'd1;
          6'd2: v = 8'd50;
          6'd4: v = 8'd50;
          6'd5: v = MARK_END;
          default: v = 8'd0;
        endcase
      end
      2'd2: begin
        if (pos == 6'd0) begin
          v = MODE_ONCE;
        end else if (pos == 6'd17) begin
          v = MARK_END;
        end else if (pos < 6'd17) begin
          if (pos[0]) begin
            v = pos[1] ? 8'd0 : 8'd1;
          end else begin
            v = 8'd50;
          end
        end
      end
      2'd3: begin
        unique case (pos)
          6'd1: v = 8'd1;
          6'd2: v = 8'd20;
          6'd4: v = 8'd20;
          6'd5: v = 8'd1;
          6'd6: v = 8'd20;
          6'd8: v = 8'd100;
          6'd9: v = MARK_END;
          default: v = 8'd0;
        endcase
      end
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/led_blink_pattern_sequencer_core.sv @@
// Warning LED sequencer top level: input register, state update, result register.
// Path: input register, then result register; an output stall can hold an item between them.
// Throughput: one item per cycle unless the output stalls; state update is a single pass of logic.
// Reset (synchronous, active high) clears control state, not data; blink interval returns to 400 ms.
// Depends on lbps_pkg, lbps_special and lbps_blink.
module led_blink_pattern_sequencer_core import lbps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [14:0] interval_ms,
  input  logic [15:0] delay_ticks,
  input  logic [2:0]  signal_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        led_on,
  output logic        blink_phase,
  output logic        special_done
);

  logic        item_valid;
  logic [1:0]  item_func;
  logic [14:0] item_interval;
  logic [15:0] item_delay;
  logic [2:0]  item_signal;

  logic        pin_level;
  logic        advance;
  logic        in_load;
  ctrl_t       ctrl;
  logic        sig_ok;

  logic        active_next;
  logic        pin_mid;
  logic        pin_next;
  logic        phase_next;

  assign advance = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_load = !in_stall;

  assign sig_ok = (item_signal >= 3'd1) && (32'(item_signal) <= NUM_SEQUENCES);

  always_comb begin
    ctrl = '0;
    unique case (item_func)
      FUNC_TICK:        ctrl.tick = 1'b1;
      FUNC_BLINK_START: ctrl.blink_start = 1'b1;
      FUNC_BLINK_STOP:  ctrl.blink_stop = 1'b1;
      FUNC_SPECIAL: begin
        ctrl.special_start = sig_ok;
        ctrl.special_stop = !sig_ok;
      end
      default: ctrl = '0;
    endcase
  end

  lbps_special u_special (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .ctrl          (ctrl),
    .signal_number (item_signal),
    .pin_level     (pin_level),
    .active_next   (active_next),
    .pin_mid       (pin_mid)
  );

  lbps_blink u_blink (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .ctrl           (ctrl),
    .interval_ms    (item_interval),
    .delay_ticks    (item_delay),
    .special_active (active_next),
    .pin_mid        (pin_mid),
    .pin_next       (pin_next),
    .phase_next     (phase_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_load) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      item_func <= func;
      item_interval <= interval_ms;
      item_delay <= delay_ticks;
      item_signal <= signal_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_level <= 1'b0;
    end else if (advance) begin
      pin_level <= pin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_on <= pin_next;
      blink_phase <= phase_next;
      special_done <= !active_next;
    end
  end

endmodule

@@ src/lbps_special.sv @@
// Special signal player: walks the pattern table on ticks and owns the pin while active.
// Depends on lbps_pkg.
module lbps_special import lbps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  ctrl_t            ctrl,
  input  logic [2:0]       signal_number,
  input  logic             pin_level,
  output logic             active_next,
  output logic             pin_mid
);

  logic             active;
  logic             was_active;
  logic             oneshot;
  logic [SEL_W-1:0] sel;
  logic [POS_W-1:0] position;
  logic [7:0]       tick_count;

  logic             was_active_next;
  logic             oneshot_next;
  logic [SEL_W-1:0] sel_next;
  logic [POS_W-1:0] position_next;
  logic [7:0]       tick_count_next;

  logic [POS_W-1:0] pos_cur;
  logic [SEL_W-1:0] start_sel;
  logic [7:0]       count_inc;
  logic             act_mid;

  always_comb begin
    active_next = active;
    was_active_next = was_active;
    oneshot_next = oneshot;
    sel_next = sel;
    position_next = position;
    tick_count_next = tick_count;
    pin_mid = pin_level;
    pos_cur = position;
    act_mid = active;
    start_sel = SEL_W'(signal_number - 3'd1);
    count_inc = tick_count + 8'd1;
    if (ctrl.tick) begin
      if (active) begin
        was_active_next = 1'b1;
        if (tick_count == 8'd0) begin
          if (rom_read(sel, position) == MARK_END) begin
            if (oneshot) begin
              act_mid = 1'b0;
              was_active_next = 1'b0;
              pin_mid = 1'b0;
            end else begin
              pos_cur = POS_W'(1);
            end
          end
          if (act_mid) begin
            pin_mid = (rom_read(sel, pos_cur) != 8'd0);
          end
        end
        active_next = act_mid;
        if (act_mid) begin
          if (count_inc >= rom_read(sel, pos_cur + POS_W'(1))) begin
            tick_count_next = 8'd0;
            position_next = pos_cur + POS_W'(2);
          end else begin
            tick_count_next = count_inc;
            position_next = pos_cur;
          end
        end
      end else if (was_active) begin
        pin_mid = 1'b0;
        was_active_next = 1'b0;
      end
    end else if (ctrl.special_start) begin
      sel_next = start_sel;
      oneshot_next = (rom_read(start_sel, POS_W'(0)) == MODE_ONCE);
      position_next = POS_W'(1);
      tick_count_next = 8'd0;
      active_next = 1'b1;
    end else if (ctrl.special_stop) begin
      active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      was_active <= 1'b0;
      oneshot <= 1'b0;
      sel <= '0;
      position <= '0;
      tick_count <= '0;
    end else if (step) begin
      active <= active_next;
      was_active <= was_active_next;
      oneshot <= oneshot_next;
      sel <= sel_next;
      position <= position_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

@@ src/lbps_blink.sv @@
// Blink timer: start delay, millisecond phase accumulator and blink phase.
// Depends on lbps_pkg.
module lbps_blink import lbps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  ctrl_t       ctrl,
  input  logic [14:0] interval_ms,
  input  logic [15:0] delay_ticks,
  input  logic        special_active,
  input  logic        pin_mid,
  output logic        pin_next,
  output logic        phase_next
);

  logic        enabled;
  logic        was_off;
  logic        phase;
  logic [15:0] accum;
  logic [14:0] interval;
  logic [15:0] delay;

  logic        enabled_next;
  logic        was_off_next;
  logic [15:0] accum_next;
  logic [14:0] interval_next;
  logic [15:0] delay_next;

  logic [15:0] acc_base;
  logic        ph_base;
  logic [16:0] sum_raw;
  logic [15:0] sum_sat;

  always_comb begin
    enabled_next = enabled;
    was_off_next = was_off;
    phase_next = phase;
    accum_next = accum;
    interval_next = interval;
    delay_next = delay;
    pin_next = pin_mid;
    acc_base = was_off ? 16'd0 : accum;
    ph_base = was_off ? 1'b1 : phase;
    sum_raw = {1'b0, acc_base} + 17'(TICK_MS);
    sum_sat = sum_raw[16] ? 16'hffff : sum_raw[15:0];
    if (ctrl.tick) begin
      if (!enabled) begin
        if (!was_off) begin
          if (!special_active) begin
            pin_next = 1'b0;
          end
          phase_next = 1'b0;
          was_off_next = 1'b1;
        end
      end else if (delay != 16'd0) begin
        delay_next = delay - 16'd1;
      end else begin
        was_off_next = 1'b0;
        if (was_off && !special_active) begin
          pin_next = 1'b1;
        end
        if (sum_sat >= {1'b0, interval}) begin
          accum_next = sum_sat - {1'b0, interval};
          phase_next = ~ph_base;
          if (!special_active) begin
            pin_next = ~ph_base;
          end
        end else begin
          accum_next = sum_sat;
          phase_next = ph_base;
        end
      end
    end else if (ctrl.blink_start) begin
      delay_next = delay_ticks;
      interval_next = interval_ms;
      enabled_next = 1'b1;
    end else if (ctrl.blink_stop) begin
      enabled_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      was_off <= 1'b0;
      phase <= 1'b0;
      accum <= '0;
      interval <= INTERVAL_RESET;
      delay <= '0;
    end else if (step) begin
      enabled <= enabled_next;
      was_off <= was_off_next;
      phase <= phase_next;
      accum <= accum_next;
      interval <= interval_next;
      delay <= delay_next;
    end
  end

endmodule
